### design/tsf_pkg.sv
`default_nettype none
package tsf_pkg;
    localparam int COORD_W = 16;
    localparam int DELTA_W = 17;
    localparam int SQ_W    = 34;
    localparam int RAD_W   = 50;
    localparam int ROOT_W  = 25;
    localparam int QUO_W   = 17;
    localparam int UNIT_W  = 18;
    localparam int FORCE_W = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_REST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STIFF = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHARE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 3'd4;

    localparam logic [1:0] MODE_PUSH = 2'd0;
    localparam logic [1:0] MODE_BOTH = 2'd1;
    localparam logic [1:0] MODE_PULL = 2'd2;
    localparam logic [1:0] MODE_NONE = 2'd3;

    localparam logic [23:0] RST_REST  = 24'd0;
    localparam logic [15:0] RST_STIFF = 16'd256;
    localparam logic [23:0] RST_BASE  = 24'd0;
    localparam logic [16:0] RST_SHARE = 17'd32768;
    localparam logic [1:0]  RST_MODE  = MODE_BOTH;
    localparam logic [16:0] SHARE_ONE = 17'd65536;

    typedef struct packed {
        logic [23:0]        rest;
        logic [15:0]        stiff;
        logic signed [23:0] base;
        logic [16:0]        share;
        logic [1:0]         mode;
    } t_cfg;

    typedef struct packed {
        logic sx;
        logic sy;
        logic nz;
    } t_dir;

    typedef struct packed {
        t_dir               dir;
        logic [DELTA_W-1:0] ax;
        logic [DELTA_W-1:0] ay;
    } t_sq_side;
endpackage
`default_nettype wire

### design/tsf_sqrt.sv
`default_nettype none
module tsf_sqrt import tsf_pkg::*; #(
    parameter int SIDE_W = 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [RAD_W-1:0]  i_rad,
    input  wire logic [SIDE_W-1:0] i_side,
    output logic                   o_valid,
    output logic [ROOT_W-1:0]      o_root,
    output logic [SIDE_W-1:0]      o_side
);
    localparam int REM_W = ROOT_W + 3;

    logic              r_valid [1:ROOT_W];
    logic [REM_W-1:0]  r_rem   [1:ROOT_W];
    logic [ROOT_W-1:0] r_root  [1:ROOT_W];
    logic [RAD_W-1:0]  r_rad   [1:ROOT_W];
    logic [SIDE_W-1:0] r_side  [1:ROOT_W];

    // one root bit per stage, two radicand bits consumed each step
    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic              in_valid;
        logic [REM_W-1:0]  in_rem;
        logic [ROOT_W-1:0] in_root;
        logic [RAD_W-1:0]  in_rad;
        logic [SIDE_W-1:0] in_side;
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;
        logic              ge;
        if (k == 0) begin : g_first
            assign in_valid = i_valid;
            assign in_rem   = '0;
            assign in_root  = '0;
            assign in_rad   = i_rad;
            assign in_side  = i_side;
        end else begin : g_next
            assign in_valid = r_valid[k];
            assign in_rem   = r_rem[k];
            assign in_root  = r_root[k];
            assign in_rad   = r_rad[k];
            assign in_side  = r_side[k];
        end
        assign rem_sh = {in_rem[REM_W-3:0], in_rad[2*(ROOT_W-1-k)+1 -: 2]};
        assign trial  = {1'b0, in_root, 2'b01};
        assign ge     = rem_sh >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k+1] <= 1'b0;
            end else if (i_en) begin
                r_valid[k+1] <= in_valid;
            end
            if (i_en) begin
                r_rem[k+1]  <= ge ? rem_sh - trial : rem_sh;
                r_root[k+1] <= {in_root[ROOT_W-2:0], ge};
                r_rad[k+1]  <= in_rad;
                r_side[k+1] <= in_side;
            end
        end
    end

    assign o_valid = r_valid[ROOT_W];
    assign o_root  = r_root[ROOT_W];
    assign o_side  = r_side[ROOT_W];
endmodule
`default_nettype wire

### design/tsf_div.sv
`default_nettype none
module tsf_div import tsf_pkg::*; #(
    parameter int SIDE_W = 1
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_valid,
    input  wire logic [ROOT_W-1:0]  i_den,
    input  wire logic [DELTA_W-1:0] i_ax,
    input  wire logic [DELTA_W-1:0] i_ay,
    input  wire logic [SIDE_W-1:0]  i_side,
    output logic                    o_valid,
    output logic [ROOT_W-1:0]       o_den,
    output logic [QUO_W-1:0]        o_qx,
    output logic [QUO_W-1:0]        o_qy,
    output logic [SIDE_W-1:0]       o_side
);
    localparam int NUM_W = DELTA_W + 25;

    logic              r_valid [1:QUO_W];
    logic [NUM_W-1:0]  r_rx    [1:QUO_W];
    logic [NUM_W-1:0]  r_ry    [1:QUO_W];
    logic [QUO_W-1:0]  r_qx    [1:QUO_W];
    logic [QUO_W-1:0]  r_qy    [1:QUO_W];
    logic [ROOT_W-1:0] r_den   [1:QUO_W];
    logic [SIDE_W-1:0] r_side  [1:QUO_W];

    // restoring division, one quotient bit per stage, both lanes share the divisor
    for (genvar j = 0; j < QUO_W; j++) begin : g_stage
        logic              in_valid;
        logic [NUM_W-1:0]  in_rx;
        logic [NUM_W-1:0]  in_ry;
        logic [QUO_W-1:0]  in_qx;
        logic [QUO_W-1:0]  in_qy;
        logic [ROOT_W-1:0] in_den;
        logic [SIDE_W-1:0] in_side;
        logic [NUM_W-1:0]  dsh;
        logic              gex;
        logic              gey;
        if (j == 0) begin : g_first
            assign in_valid = i_valid;
            assign in_rx    = {1'b0, i_ax, 24'd0};
            assign in_ry    = {1'b0, i_ay, 24'd0};
            assign in_qx    = '0;
            assign in_qy    = '0;
            assign in_den   = i_den;
            assign in_side  = i_side;
        end else begin : g_next
            assign in_valid = r_valid[j];
            assign in_rx    = r_rx[j];
            assign in_ry    = r_ry[j];
            assign in_qx    = r_qx[j];
            assign in_qy    = r_qy[j];
            assign in_den   = r_den[j];
            assign in_side  = r_side[j];
        end
        assign dsh = {{(NUM_W-ROOT_W){1'b0}}, in_den} << (QUO_W-1-j);
        assign gex = in_rx >= dsh;
        assign gey = in_ry >= dsh;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[j+1] <= 1'b0;
            end else if (i_en) begin
                r_valid[j+1] <= in_valid;
            end
            if (i_en) begin
                r_rx[j+1]   <= gex ? in_rx - dsh : in_rx;
                r_ry[j+1]   <= gey ? in_ry - dsh : in_ry;
                r_qx[j+1]   <= {in_qx[QUO_W-2:0], gex};
                r_qy[j+1]   <= {in_qy[QUO_W-2:0], gey};
                r_den[j+1]  <= in_den;
                r_side[j+1] <= in_side;
            end
        end
    end

    assign o_valid = r_valid[QUO_W];
    assign o_den   = r_den[QUO_W];
    assign o_qx    = r_qx[QUO_W];
    assign o_qy    = r_qy[QUO_W];
    assign o_side  = r_side[QUO_W];
endmodule
`default_nettype wire

### design/tsf_force.sv
`default_nettype none
module tsf_force import tsf_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_valid,
    input  wire logic [ROOT_W-1:0]  i_d8,
    input  wire logic [QUO_W-1:0]   i_qx,
    input  wire logic [QUO_W-1:0]   i_qy,
    input  wire t_dir               i_dir,
    input  wire t_cfg               i_cfg,
    output logic                    o_valid,
    output logic signed [FORCE_W-1:0] o_fax,
    output logic signed [FORCE_W-1:0] o_fay,
    output logic signed [FORCE_W-1:0] o_fbx,
    output logic signed [FORCE_W-1:0] o_fby
);
    localparam int DIFF_W = ROOT_W + 1;
    localparam int MAG_W  = 44;
    localparam int S2_W   = MAG_W + 1;
    localparam int PRD_W  = S2_W + UNIT_W;
    localparam int SH_W   = PRD_W - 16;
    localparam logic signed [SH_W-1:0] SAT_HI = SH_W'(64'sd2147483647);
    localparam logic signed [SH_W-1:0] SAT_LO = -SH_W'(64'sd2147483648);

    logic [6:1] r_valid;
    logic [6:1] r_ok;

    logic signed [DIFF_W-1:0] r1_diff;
    logic signed [UNIT_W-1:0] r1_ux, r1_uy;
    logic signed [MAG_W-1:0]  r2_mag;
    logic signed [UNIT_W-1:0] r2_ux, r2_uy;
    logic signed [MAG_W-1:0]  r3_mag, r3_s1;
    logic signed [UNIT_W-1:0] r3_ux, r3_uy;
    logic signed [S2_W-1:0]   r4_s1, r4_s2;
    logic signed [UNIT_W-1:0] r4_ux, r4_uy;
    logic signed [SH_W-1:0]   r5_ax, r5_ay, r5_bx, r5_by;

    logic                     counted;
    logic signed [DIFF_W-1:0] diff;
    logic [16:0]              share;
    logic signed [MAG_W+18-1:0] prod_s;
    logic signed [PRD_W-1:0]  p_ax, p_ay, p_bx, p_by;

    function automatic logic signed [FORCE_W-1:0] sat(input logic signed [SH_W-1:0] v);
        if (v > SAT_HI) begin
            return FORCE_W'(SAT_HI);
        end else if (v < SAT_LO) begin
            return FORCE_W'(SAT_LO);
        end
        return FORCE_W'(v);
    endfunction

    always_comb begin
        diff = $signed({1'b0, i_d8}) - $signed({2'b00, i_cfg.rest});
        case (i_cfg.mode)
            MODE_PUSH: counted = diff < 0;
            MODE_BOTH: counted = diff != 0;
            MODE_PULL: counted = diff > 0;
            default:   counted = 1'b0;
        endcase
        share  = (i_cfg.share > SHARE_ONE) ? SHARE_ONE : i_cfg.share;
        prod_s = r2_mag * $signed({1'b0, share});
        p_ax   = r4_s2 * r4_ux;
        p_ay   = r4_s2 * r4_uy;
        p_bx   = r4_s1 * (-r4_ux);
        p_by   = r4_s1 * (-r4_uy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[5:1], i_valid};
        end
        if (i_en) begin
            r_ok    <= {r_ok[5:1], counted & i_dir.nz};
            // stage 1: excess and signed unit components
            r1_diff <= diff;
            r1_ux   <= i_dir.sx ? -$signed({1'b0, i_qx}) : $signed({1'b0, i_qx});
            r1_uy   <= i_dir.sy ? -$signed({1'b0, i_qy}) : $signed({1'b0, i_qy});
            // stage 2: magnitude
            r2_mag  <= MAG_W'(r1_diff * $signed({1'b0, i_cfg.stiff}))
                       + MAG_W'($signed({i_cfg.base, 8'd0}));
            r2_ux   <= r1_ux;
            r2_uy   <= r1_uy;
            // stage 3: share of the first end, floored
            r3_mag  <= r2_mag;
            r3_s1   <= MAG_W'(prod_s >>> 16);
            r3_ux   <= r2_ux;
            r3_uy   <= r2_uy;
            // stage 4: remainder goes to the other end
            r4_s1   <= S2_W'(r3_s1);
            r4_s2   <= S2_W'(r3_mag) - S2_W'(r3_s1);
            r4_ux   <= r3_ux;
            r4_uy   <= r3_uy;
            // stage 5: scale along the unit vectors
            r5_ax   <= SH_W'(p_ax >>> 16);
            r5_ay   <= SH_W'(p_ay >>> 16);
            r5_bx   <= SH_W'(p_bx >>> 16);
            r5_by   <= SH_W'(p_by >>> 16);
            // stage 6: saturate, drop uncounted items to zero
            o_fax   <= r_ok[5] ? sat(r5_ax) : '0;
            o_fay   <= r_ok[5] ? sat(r5_ay) : '0;
            o_fbx   <= r_ok[5] ? sat(r5_bx) : '0;
            o_fby   <= r_ok[5] ? sat(r5_by) : '0;
        end
    end

    assign o_valid = r_valid[6];
endmodule
`default_nettype wire

### design/tether_spring_force_2d_unit.sv
// channel | handshake          | payload
// in      | i_valid / o_ready  | i_first_x, i_first_y, i_second_x, i_second_y
// out     | o_valid / i_ready  | o_force_a_x, o_force_a_y, o_force_b_x, o_force_b_y
// cfg     | i_cfg_we           | i_cfg_idx, i_cfg_data
// One item per cycle sustained unless the output stalls; 3 front stages, 25 root
// stages, 17 divider stages, 6 force stages, the last being the output register.
// The whole pipeline advances together whenever the output register is empty
// or being taken; otherwise every stage holds.
// Reset clears all valid bits and loads the register defaults.
`default_nettype none
module tether_spring_force_2d_unit import tsf_pkg::*; (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic signed [COORD_W-1:0] i_first_x,
    input  wire logic signed [COORD_W-1:0] i_first_y,
    input  wire logic signed [COORD_W-1:0] i_second_x,
    input  wire logic signed [COORD_W-1:0] i_second_y,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic signed [FORCE_W-1:0]      o_force_a_x,
    output logic signed [FORCE_W-1:0]      o_force_a_y,
    output logic signed [FORCE_W-1:0]      o_force_b_x,
    output logic signed [FORCE_W-1:0]      o_force_b_y,
    input  wire logic                      i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]     i_cfg_data
);
    localparam int SQ_SIDE_W = $bits(t_sq_side);
    localparam int DIR_W     = $bits(t_dir);

    t_cfg r_cfg;
    logic en;

    logic                      r1_valid, r2_valid, r3_valid;
    t_sq_side                  r1_side, r2_side, r3_side;
    logic [SQ_W-1:0]           r2_sqx, r2_sqy;
    logic [SQ_W-1:0]           r3_d2;
    logic signed [DELTA_W-1:0] dx, dy;

    logic                 sq_valid;
    logic [ROOT_W-1:0]    sq_root;
    logic [SQ_SIDE_W-1:0] sq_side_v;
    t_sq_side             sq_side;
    logic                 dv_valid;
    logic [ROOT_W-1:0]    dv_den;
    logic [QUO_W-1:0]     dv_qx, dv_qy;
    logic [DIR_W-1:0]     dv_side;
    t_dir                 dv_dir;

    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rest  <= RST_REST;
            r_cfg.stiff <= RST_STIFF;
            r_cfg.base  <= RST_BASE;
            r_cfg.share <= RST_SHARE;
            r_cfg.mode  <= RST_MODE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_REST:  r_cfg.rest  <= i_cfg_data;
                CFG_STIFF: r_cfg.stiff <= i_cfg_data[15:0];
                CFG_BASE:  r_cfg.base  <= i_cfg_data;
                CFG_SHARE: r_cfg.share <= i_cfg_data[16:0];
                CFG_MODE:  r_cfg.mode  <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    assign dx = DELTA_W'(i_second_x) - DELTA_W'(i_first_x);
    assign dy = DELTA_W'(i_second_y) - DELTA_W'(i_first_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
        if (en) begin
            r1_side.dir.sx <= dx[DELTA_W-1];
            r1_side.dir.sy <= dy[DELTA_W-1];
            r1_side.dir.nz <= (dx != 0) || (dy != 0);
            r1_side.ax     <= dx[DELTA_W-1] ? -dx : dx;
            r1_side.ay     <= dy[DELTA_W-1] ? -dy : dy;
            r2_sqx  <= r1_side.ax * r1_side.ax;
            r2_sqy  <= r1_side.ay * r1_side.ay;
            r2_side <= r1_side;
            r3_d2   <= r2_sqx + r2_sqy;
            r3_side <= r2_side;
        end
    end

    tsf_sqrt #(.SIDE_W(SQ_SIDE_W)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r3_valid),
        .i_rad   ({r3_d2, 16'd0}),
        .i_side  (r3_side),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_side  (sq_side_v)
    );
    assign sq_side = t_sq_side'(sq_side_v);

    tsf_div #(.SIDE_W(DIR_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_valid),
        .i_den   (sq_root),
        .i_ax    (sq_side.ax),
        .i_ay    (sq_side.ay),
        .i_side  (sq_side.dir),
        .o_valid (dv_valid),
        .o_den   (dv_den),
        .o_qx    (dv_qx),
        .o_qy    (dv_qy),
        .o_side  (dv_side)
    );
    assign dv_dir = t_dir'(dv_side);

    tsf_force u_force (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (dv_valid),
        .i_d8    (dv_den),
        .i_qx    (dv_qx),
        .i_qy    (dv_qy),
        .i_dir   (dv_dir),
        .i_cfg   (r_cfg),
        .o_valid (o_valid),
        .o_fax   (o_force_a_x),
        .o_fay   (o_force_a_y),
        .o_fbx   (o_force_b_x),
        .o_fby   (o_force_b_y)
    );

    a_rst_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");
    a_mode_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_cfg.mode == MODE_NONE) |->
        (o_force_a_x == 0 && o_force_a_y == 0 && o_force_b_x == 0 && o_force_b_y == 0))
        else $error("force with tether disabled");
    a_opposed_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_force_a_x[FORCE_W-1] && o_force_b_x[FORCE_W-1]))
        else $error("x forces not opposed");
    a_opposed_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_force_a_y[FORCE_W-1] && o_force_b_y[FORCE_W-1]))
        else $error("y forces not opposed");
endmodule
`default_nettype wire
